// ----- rtl/cnms_pkg.sv -----
// shared types and constants for the class aware box suppression block
package cnms_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int IOU_LAT   = 3;
    localparam int TMR_W     = $clog2(IOU_LAT + 1);

    typedef struct packed {
        logic [15:0]      left;
        logic [15:0]      top;
        logic [15:0]      right;
        logic [15:0]      bottom;
        logic [15:0]      score;
        logic [7:0]       cls;
        logic [IDX_W-1:0] idx;
    } t_box;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_POP,
        CMD_MARK
    } t_cmd;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        t_cmd  cmd;
        t_box  new_box;
        t_box  probe;
        logic [16:0] thr;
    } t_cell_ctl;

    // what one cell shows its neighbors
    typedef struct packed {
        t_box box;
        logic valid;
        logic sup;
        logic ins;
    } t_cell_link;

endpackage

// ----- rtl/cnms_iou.sv -----
// pipelined overlap test of one stored box against the probe box
module cnms_iou (
    input  logic               i_clk,
    input  cnms_pkg::t_box     i_a,
    input  cnms_pkg::t_box     i_b,
    input  logic [16:0]        i_thr,
    output logic               o_hit
);
    logic signed [16:0] w_x1, w_y1, w_x2, w_y2;
    logic signed [16:0] r_w, r_h, r_wa, r_ha, r_wb, r_hb;
    logic signed [33:0] r_inter, r_ap, r_aq;
    logic               r_pos1, r_pos2, r_pos3;
    logic signed [35:0] r_uni;
    logic        [33:0] r_inter3;
    logic        [51:0] w_lhs, w_rhs;

    always_comb begin
        w_x1 = (i_a.left > i_b.left)     ? {1'b0, i_a.left}   : {1'b0, i_b.left};
        w_y1 = (i_a.top > i_b.top)       ? {1'b0, i_a.top}    : {1'b0, i_b.top};
        w_x2 = (i_a.right < i_b.right)   ? {1'b0, i_a.right}  : {1'b0, i_b.right};
        w_y2 = (i_a.bottom < i_b.bottom) ? {1'b0, i_a.bottom} : {1'b0, i_b.bottom};
    end

    always_ff @(posedge i_clk) begin
        r_w    <= w_x2 - w_x1;
        r_h    <= w_y2 - w_y1;
        r_wa   <= $signed({1'b0, i_a.right})  - $signed({1'b0, i_a.left});
        r_ha   <= $signed({1'b0, i_a.bottom}) - $signed({1'b0, i_a.top});
        r_wb   <= $signed({1'b0, i_b.right})  - $signed({1'b0, i_b.left});
        r_hb   <= $signed({1'b0, i_b.bottom}) - $signed({1'b0, i_b.top});
        r_pos1 <= (w_x2 > w_x1) && (w_y2 > w_y1);

        r_inter <= r_w * r_h;
        r_ap    <= r_wa * r_ha;
        r_aq    <= r_wb * r_hb;
        r_pos2  <= r_pos1;

        r_uni    <= 36'(r_ap) + 36'(r_aq) - 36'(r_inter);
        r_inter3 <= r_inter[33:0];
        r_pos3   <= r_pos2;
    end

    assign w_lhs = {2'b0, r_inter3, 16'h0000};
    assign w_rhs = 52'(i_thr) * 52'(r_uni[34:0]);
    assign o_hit = r_pos3 && (r_uni > 36'sd0) && (w_lhs > w_rhs);
endmodule

// ----- rtl/cnms_cell.sv -----
// one cell of the sorted box chain: holds a box and its suppression flag
module cnms_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cnms_pkg::t_cell_ctl  i_ctl,
    input  cnms_pkg::t_cell_link i_prev,
    input  cnms_pkg::t_cell_link i_next,
    output cnms_pkg::t_cell_link o_link
);
    cnms_pkg::t_box r_box;
    logic           r_valid;
    logic           r_sup;
    logic           w_ins;
    logic           w_hit;

    // insertion point: later equal scores stay behind earlier ones
    assign w_ins = !r_valid || (r_box.score < i_ctl.new_box.score);

    cnms_iou u_iou (
        .i_clk (i_clk),
        .i_a   (r_box),
        .i_b   (i_ctl.probe),
        .i_thr (i_ctl.thr),
        .o_hit (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sup   <= 1'b0;
        end else begin
            unique case (i_ctl.cmd)
                cnms_pkg::CMD_INSERT: begin
                    if (w_ins && !i_prev.ins) begin
                        r_box   <= i_ctl.new_box;
                        r_valid <= 1'b1;
                        r_sup   <= 1'b0;
                    end else if (w_ins) begin
                        r_box   <= i_prev.box;
                        r_valid <= i_prev.valid;
                        r_sup   <= i_prev.sup;
                    end
                end
                cnms_pkg::CMD_POP: begin
                    r_box   <= i_next.box;
                    r_valid <= i_next.valid;
                    r_sup   <= i_next.sup;
                end
                cnms_pkg::CMD_MARK: begin
                    if (r_valid && (r_box.cls == i_ctl.probe.cls) && w_hit)
                        r_sup <= 1'b1;
                end
                cnms_pkg::CMD_HOLD: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_link.box   = r_box;
    assign o_link.valid = r_valid;
    assign o_link.sup   = r_sup;
    assign o_link.ins   = w_ins;
endmodule

// ----- rtl/class_aware_box_nms.sv -----
// top level: box loading, sorted cell chain, suppression sequencer and output stage
//
// Input stream: one box per request on the s_axis group, tlast closes the set.
// While loading, a box is taken every cycle; each request inserts the box into
// its score position in a chain of 64 cells, equal scores behind earlier ones.
// Boxes beyond 64 are dropped and the results of that set carry tuser = 1.
// After tlast the chain is popped from its head, one cell a cycle while heads
// are suppressed. A head that is still unsuppressed is compared against all
// remaining cells in parallel through a 3 stage overlap pipeline, and the
// sequencer waits on that compare and on the emit step before the next pop.
// Results leave through an output register on the m_axis group, tlast on the
// final kept box. A stalled receiver holds the sequencer at the emit step; a
// new set may start loading while the final result still waits.
// Config: i_cfg_valid/o_cfg_ready write the 17 bit overlap threshold, reset
// value 32768; write it only while no set is in progress.
// Reset (synchronous, active low) empties the chain and the output register.
module class_aware_box_nms (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // box_left, box_top, box_right, box_bottom, box_score, box_class
    input  logic [87:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kept_left, kept_top, kept_right, kept_bottom, kept_score, kept_class,
    // source_index, zero pad
    output logic [95:0] m_axis_tdata,
    // overflow
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);
    typedef enum logic [1:0] {S_LOAD, S_POP, S_WAIT, S_EMIT} t_state;

    t_state                       r_state;
    logic [cnms_pkg::CNT_W-1:0]   r_count;
    logic                         r_ovf;
    logic [16:0]                  r_thr;
    logic [cnms_pkg::TMR_W-1:0]   r_tmr;
    cnms_pkg::t_box               r_head;
    logic                         r_out_valid;
    cnms_pkg::t_box               r_out_box;
    logic                         r_out_last;
    logic                         r_out_ovf;

    cnms_pkg::t_cell_ctl          w_ctl;
    cnms_pkg::t_cell_link         w_link [cnms_pkg::MAX_BOXES];
    cnms_pkg::t_cell_link         w_edge;
    cnms_pkg::t_box               w_new;
    logic [cnms_pkg::MAX_BOXES-1:0] w_valid;
    logic [cnms_pkg::MAX_BOXES-1:0] w_live;
    logic                         w_in_req;
    logic                         w_out_free;

    assign w_in_req   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_new.left   = s_axis_tdata[15:0];
    assign w_new.top    = s_axis_tdata[31:16];
    assign w_new.right  = s_axis_tdata[47:32];
    assign w_new.bottom = s_axis_tdata[63:48];
    assign w_new.score  = s_axis_tdata[79:64];
    assign w_new.cls    = s_axis_tdata[87:80];
    assign w_new.idx    = r_count[cnms_pkg::IDX_W-1:0];

    assign w_edge = '0;

    always_comb begin
        w_ctl.new_box = w_new;
        w_ctl.probe   = r_head;
        w_ctl.thr     = r_thr;
        w_ctl.cmd     = cnms_pkg::CMD_HOLD;
        unique case (r_state)
            S_LOAD: if (w_in_req && (r_count < cnms_pkg::CNT_W'(cnms_pkg::MAX_BOXES)))
                        w_ctl.cmd = cnms_pkg::CMD_INSERT;
            S_POP:  if (w_link[0].valid)
                        w_ctl.cmd = cnms_pkg::CMD_POP;
            S_WAIT: if (r_tmr == cnms_pkg::TMR_W'(cnms_pkg::IOU_LAT))
                        w_ctl.cmd = cnms_pkg::CMD_MARK;
            S_EMIT: w_ctl.cmd = cnms_pkg::CMD_HOLD;
            default: w_ctl.cmd = cnms_pkg::CMD_HOLD;
        endcase
    end

    for (genvar g = 0; g < cnms_pkg::MAX_BOXES; g++) begin : g_cell
        cnms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  ((g == 0) ? w_edge : w_link[(g == 0) ? 0 : g - 1]),
            .i_next  ((g == cnms_pkg::MAX_BOXES - 1) ? w_edge
                      : w_link[(g == cnms_pkg::MAX_BOXES - 1) ? g : g + 1]),
            .o_link  (w_link[g])
        );
        assign w_valid[g] = w_link[g].valid;
        assign w_live[g]  = w_link[g].valid && !w_link[g].sup;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_thr       <= 17'd32768;
            r_tmr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid)
                r_thr <= i_cfg_data;
            if (r_state == S_EMIT && w_out_free)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_req) begin
                        if (r_count < cnms_pkg::CNT_W'(cnms_pkg::MAX_BOXES))
                            r_count <= r_count + 1'b1;
                        else
                            r_ovf <= 1'b1;
                        if (s_axis_tlast)
                            r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (!w_link[0].valid) begin
                        r_state <= S_LOAD;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end else if (!w_link[0].sup) begin
                        r_head  <= w_link[0].box;
                        r_tmr   <= '0;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (r_tmr == cnms_pkg::TMR_W'(cnms_pkg::IOU_LAT))
                        r_state <= S_EMIT;
                    else
                        r_tmr <= r_tmr + 1'b1;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_box   <= r_head;
                        r_out_last  <= ~|w_live;
                        r_out_ovf   <= r_ovf;
                        r_state     <= S_POP;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_LOAD);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_box.idx, r_out_box.cls, r_out_box.score,
                            r_out_box.bottom, r_out_box.right, r_out_box.top,
                            r_out_box.left};
    assign m_axis_tuser  = r_out_ovf;
    assign m_axis_tlast  = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cnms_pkg::CNT_W'(cnms_pkg::MAX_BOXES))
        else $error("box count beyond capacity");

    a_head_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_count != '0) |-> w_valid[0])
        else $error("loaded boxes missing from chain head");

    a_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_count == '0) |-> (w_valid == '0))
        else $error("chain not empty at start of set");

    a_emit_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) == S_WAIT || $past(r_state) == S_EMIT))
        else $error("emit step entered without compare");
endmodule

// ----- tb/sv/tb_class_aware_box_nms.sv -----
// self-checking testbench for the class aware box suppression block
module tb_class_aware_box_nms;

    localparam int LIMIT = 2000000;

    typedef struct {
        logic [15:0] left, top, right, bottom, score;
        logic [7:0]  cls;
        logic        last;
    } t_box_req;

    typedef struct packed {
        logic [15:0] left, top, right, bottom, score;
        logic [7:0]  cls;
        logic [5:0]  src;
        logic        last;
        logic        ovf;
    } t_kept_box;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [95:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;

    class_aware_box_nms uut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    t_box_req  box_queue[$];
    t_kept_box kept_queue[$];
    t_box_req  set_boxes[$];
    logic [16:0] iou_thr = 17'd32768;
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;
    bit  send_pause = 0;
    logic in_fire = 0;

    // exact integer overlap test, signed areas
    function automatic bit too_close(t_box_req p, t_box_req q);
        longint x1, y1, x2, y2, w, h, inter, ap, aq, uni;
        x1 = p.left > q.left ? p.left : q.left;
        y1 = p.top > q.top ? p.top : q.top;
        x2 = p.right < q.right ? p.right : q.right;
        y2 = p.bottom < q.bottom ? p.bottom : q.bottom;
        w = x2 - x1;
        h = y2 - y1;
        if (w <= 0 || h <= 0) return 0;
        inter = w * h;
        ap = (longint'(p.right) - longint'(p.left)) * (longint'(p.bottom) - longint'(p.top));
        aq = (longint'(q.right) - longint'(q.left)) * (longint'(q.bottom) - longint'(q.top));
        uni = ap + aq - inter;
        if (uni <= 0) return 0;
        return inter * 65536 > longint'(iou_thr) * uni;
    endfunction

    // sort the closed set, suppress, and queue the surviving boxes
    task automatic predict_kept_boxes(bit ovf);
        int order[$];
        bit gone[64];
        int n, i, j, last_pos;
        t_kept_box k;
        n = set_boxes.size();
        for (i = 0; i < n; i++) begin
            j = 0;
            while (j < order.size() && set_boxes[order[j]].score >= set_boxes[i].score) j++;
            order.insert(j, i);
        end
        for (i = 0; i < 64; i++) gone[i] = 0;
        for (i = 0; i < n; i++) begin
            if (gone[i]) continue;
            for (j = i + 1; j < n; j++) begin
                if (gone[j] || set_boxes[order[i]].cls != set_boxes[order[j]].cls) continue;
                if (too_close(set_boxes[order[i]], set_boxes[order[j]])) gone[j] = 1;
            end
        end
        last_pos = 0;
        for (i = 0; i < n; i++) if (!gone[i]) last_pos = i;
        for (i = 0; i < n; i++) begin
            if (gone[i]) continue;
            k.left = set_boxes[order[i]].left;
            k.top = set_boxes[order[i]].top;
            k.right = set_boxes[order[i]].right;
            k.bottom = set_boxes[order[i]].bottom;
            k.score = set_boxes[order[i]].score;
            k.cls = set_boxes[order[i]].cls;
            k.src = 6'(order[i]);
            k.last = (i == last_pos);
            k.ovf = ovf;
            kept_queue.push_back(k);
        end
        set_boxes.delete();
    endtask

    bit set_ovf = 0;

    // request taken at the last rising edge
    always @(posedge i_clk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_fire) begin
                // hold the request
            end else if (box_queue.size() > 0 && !send_pause
                         && $urandom_range(99) >= send_idle_pct) begin
                t_box_req b;
                b = box_queue.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tdata <= {b.cls, b.score, b.bottom, b.right, b.top, b.left};
                s_axis_tlast <= b.last;
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // receiver ready, with long hold-off counted in cycles
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off > 0) begin
                m_axis_tready <= 0;
                hold_off <= hold_off - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // input monitor feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_box_req b;
            {b.cls, b.score, b.bottom, b.right, b.top, b.left} = s_axis_tdata;
            b.last = s_axis_tlast;
            if (set_boxes.size() < cnms_pkg::MAX_BOXES) set_boxes.push_back(b);
            else set_ovf = 1;
            if (b.last) begin
                predict_kept_boxes(set_ovf);
                set_ovf = 0;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_kept_box a, e;
            {a.src, a.cls, a.score, a.bottom, a.right, a.top, a.left} = m_axis_tdata[93:0];
            a.last = m_axis_tlast;
            a.ovf = m_axis_tuser[0];
            if (kept_queue.size() == 0) begin
                errors++;
                $display("%0t unexpected result %p", $time, a);
            end else begin
                e = kept_queue.pop_front();
                if (a !== e) begin
                    errors++;
                    $display("%0t mismatch expected %p actual %p", $time, e, a);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_box_req rand_box(bit last, bit clustered);
        t_box_req b;
        logic [15:0] x, y;
        if (clustered) begin
            x = 16'($urandom_range(2000, 0));
            y = 16'($urandom_range(2000, 0));
            b.left = 16'(x + $urandom_range(40));
            b.top = 16'(y + $urandom_range(40));
            b.right = 16'(x + 200 + $urandom_range(60));
            b.bottom = 16'(y + 200 + $urandom_range(60));
            if ($urandom_range(19) == 0) b.right = b.left - 16'd5; // reversed
            b.cls = 8'($urandom_range(2));
            b.score = ($urandom_range(3) == 0) ? 16'd40000 : 16'($urandom);
        end else begin
            b.left = 16'($urandom);
            b.top = 16'($urandom);
            b.right = 16'($urandom);
            b.bottom = 16'($urandom);
            b.cls = 8'($urandom);
            b.score = 16'($urandom);
        end
        b.last = last;
        return b;
    endfunction

    task automatic wait_drained();
        while (box_queue.size() > 0 || s_axis_tvalid || kept_queue.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [16:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        iou_thr = v;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic queue_random_sets(int total);
        int sent, n, i;
        sent = 0;
        while (sent < total) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(66, 40) : $urandom_range(12, 1);
            for (i = 0; i < n; i++)
                box_queue.push_back(rand_box(i == n - 1, $urandom_range(9) != 0));
            sent += n;
        end
    endtask

    initial begin
        t_box_req b;
        int i;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: extremes, ties, reversed corners, disjoint boxes, one-box set
        b = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0};
        box_queue.push_back(b);
        b = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0};
        box_queue.push_back(b);
        b = '{16'h0100, 16'h0100, 16'h0010, 16'h0010, 16'h0000, 8'h00, 1'b0};
        box_queue.push_back(b);
        b = '{16'h0000, 16'h0000, 16'h0010, 16'h0010, 16'h8000, 8'h00, 1'b0};
        box_queue.push_back(b);
        b = '{16'h0020, 16'h0020, 16'h0030, 16'h0030, 16'h8000, 8'h00, 1'b0};
        box_queue.push_back(b);
        b = '{16'h0001, 16'h0001, 16'h0011, 16'h0011, 16'h7000, 8'h00, 1'b1};
        box_queue.push_back(b);
        b = '{16'h1234, 16'h5678, 16'h2345, 16'h6789, 16'h0001, 8'h80, 1'b1};
        box_queue.push_back(b);
        wait_drained();
        // overflowing set: 70 boxes
        for (i = 0; i < 70; i++) box_queue.push_back(rand_box(i == 69, 1));
        wait_drained();

        write_threshold(17'd0);
        queue_random_sets(40);
        wait_drained();
        write_threshold(17'd65536);
        queue_random_sets(40);
        wait_drained();
        write_threshold(17'd20000);
        send_idle_pct = 48;
        queue_random_sets(60);
        wait_drained();
        write_threshold(17'd45000);
        send_idle_pct = 0;
        recv_stall_pct = 48;
        hold_off = 600;
        queue_random_sets(60);
        wait_drained();
        write_threshold(17'd32768);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        queue_random_sets(40);
        // pause the sender part way until every expected result is out
        while (box_queue.size() > 20) @(posedge i_clk);
        send_pause = 1;
        while (kept_queue.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        send_pause = 0;
        queue_random_sets(30);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/cnms_pkg.sv
rtl/cnms_iou.sv
rtl/cnms_cell.sv
rtl/class_aware_box_nms.sv
tb/sv/tb_class_aware_box_nms.sv
